### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTL; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Expression must never be true
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

// Consequent must hold after the antecedent, as a delayed check
`define ASSERT_AFTER3(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error("delayed response check failed");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`define ASSERT_AFTER3(name, clk, rst_n, ante, cons)

`endif

`endif

### src/dtfs_pkg.sv
// ---------------------------------------------------------------------------
// dtfs_pkg
// Shared constants, codes and elaboration-time helpers of the flow splat.
// ---------------------------------------------------------------------------
package dtfs_pkg;

    // Default geometry
    localparam int MAX_MAP_WIDTH_DEF  = 64;
    localparam int MAX_MAP_HEIGHT_DEF = 64;
    localparam int CELL_SIZE_DEF      = 4;
    localparam int SPLAT_RADIUS_DEF   = 1;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_PREF_DIR   = 2'd0;
    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

    // Angles in 1/64 degree
    localparam int FULL_TURN   = 23040;
    localparam int FIFTEEN_DEG = 960;
    localparam int THIRTY_DEG  = 1920;

    // Tuning is floor(M / 75); M times RECIP_75 >> RECIP_SHIFT is exact for M < 2^22
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_75    = 14316558;
    localparam int TUNE_BIAS   = 37;

    // Reset values of the registers
    localparam logic [14:0] PREF_DIR_RST   = 15'd0;
    localparam logic [6:0]  MAP_WIDTH_RST  = 7'd64;
    localparam logic [6:0]  MAP_HEIGHT_RST = 7'd64;

    // Integer square root, used only on constants at elaboration
    function automatic longint unsigned isqrt64(input longint unsigned value);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = value;
        root  = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 64'd0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

endpackage

### src/dtfs_tune.sv
// ---------------------------------------------------------------------------
// dtfs_tune
// Five-stage pipeline: angle wrap, circular difference, tuning numerator,
// reciprocal divide, and scaling of the strength by the Q1.15 tuning.
// flow_angle is sampled with in_valid; flow_value must stay stable until
// out_valid.
// ---------------------------------------------------------------------------
module dtfs_tune
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [15:0] flow_angle,
    input  logic signed [15:0] flow_value,
    input  logic        [14:0] preferred_direction,
    output logic               out_valid,
    output logic signed [31:0] scaled
);

    localparam logic signed [17:0] TURN_S   = 18'(dtfs_pkg::FULL_TURN);
    localparam logic        [14:0] TURN_U   = 15'(dtfs_pkg::FULL_TURN);
    localparam logic        [14:0] DEG15    = 15'(dtfs_pkg::FIFTEEN_DEG);
    localparam logic        [14:0] DEG30    = 15'(dtfs_pkg::THIRTY_DEG);
    localparam logic        [14:0] NEAR_DEN = 15'(5 * dtfs_pkg::FIFTEEN_DEG);
    localparam logic        [23:0] RECIP    = 24'(dtfs_pkg::RECIP_75);
    localparam logic        [21:0] BIAS     = 22'(dtfs_pkg::TUNE_BIAS);

    logic [4:0] vld_reg, vld_next;

    logic        [14:0] ang_reg, ang_next;
    logic        [14:0] pref_reg, pref_next;
    logic        [13:0] diff_reg, diff_next;
    logic        [21:0] num_reg, num_next;
    logic        [15:0] tune_reg, tune_next;
    logic signed [31:0] scaled_reg, scaled_next;

    logic signed [17:0] ang_ext;
    logic signed [17:0] ang_wrap;
    logic        [14:0] d1;
    logic        [14:0] d2;
    logic        [14:0] dmin;
    logic        [45:0] recip_prod;
    logic signed [32:0] scale_prod;

    // Wrap both angles into one turn
    assign ang_ext = {{2{flow_angle[15]}}, flow_angle};

    always_comb
    begin
        if (ang_ext < -TURN_S)
            ang_wrap = ang_ext + (TURN_S <<< 1);
        else if (ang_ext < 18'sd0)
            ang_wrap = ang_ext + TURN_S;
        else if (ang_ext >= TURN_S)
            ang_wrap = ang_ext - TURN_S;
        else
            ang_wrap = ang_ext;
    end

    assign ang_next  = ang_wrap[14:0];
    assign pref_next = (preferred_direction >= TURN_U) ? preferred_direction - TURN_U
                                                       : preferred_direction;

    // Circular difference, 0 to half a turn
    assign d1        = (ang_reg >= pref_reg) ? ang_reg - pref_reg : pref_reg - ang_reg;
    assign d2        = TURN_U - d1;
    assign dmin      = (d1 > d2) ? d2 : d1;
    assign diff_next = dmin[13:0];

    // Numerator of the tuning, already divided by the power-of-two part
    always_comb
    begin
        if ({1'b0, diff_reg} < DEG15)
            num_next = (22'(NEAR_DEN - {1'b0, diff_reg}) << 9) + BIAS;
        else if ({1'b0, diff_reg} < DEG30)
            num_next = (22'(DEG30 - {1'b0, diff_reg}) << 11) + BIAS;
        else
            num_next = 22'd0;
    end

    // Divide by 75 through the reciprocal
    assign recip_prod = 46'(num_reg) * 46'(RECIP);
    assign tune_next  = recip_prod[dtfs_pkg::RECIP_SHIFT +: 16];

    // Scale the strength
    assign scale_prod  = $signed({1'b0, tune_reg}) * flow_value;
    assign scaled_next = scale_prod[31:0];

    assign vld_next = {vld_reg[3:0], in_valid};

    // Advance the valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        ang_reg    <= ang_next;
        pref_reg   <= pref_next;
        diff_reg   <= diff_next;
        num_reg    <= num_next;
        tune_reg   <= tune_next;
        scaled_reg <= scaled_next;
    end

    assign out_valid = vld_reg[4];
    assign scaled    = scaled_reg;

endmodule

### src/direction_tuned_flow_splat.sv
// ---------------------------------------------------------------------------
// direction_tuned_flow_splat
// Direction-tuned optical flow splat into a downsampled Q16.16 response map.
// ---------------------------------------------------------------------------
// Usage:
//  An item is taken at a clock edge with start high and busy low. operation
//  selects clear, accumulate or read; other codes are taken and ignored.
//  Only a read returns a result: result_valid is high for one cycle with
//  cell_value, after the states ST_READ and ST_FETCH that follow the
//  accepting edge; the receiver cannot stall. busy is low again in the
//  cycle the result shows, so a new item can follow at once.
//  Accumulate runs the tuning pipeline, then one read-modify-write per
//  neighbor cell through a pipe on the map memory's single read and write
//  port, then a drain of that pipe; (2R+1)^2 cells per item, 9 for R = 1.
//  Clear writes zero to every map entry, one per cycle. After reset the
//  same sweep runs over all MAX_MAP_WIDTH * MAX_MAP_HEIGHT entries (4096 by
//  default) with busy high; register writes are taken throughout.
//  The register port always has cfg_ready high; write only while idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module direction_tuned_flow_splat
#(
    parameter int MAX_MAP_WIDTH  = dtfs_pkg::MAX_MAP_WIDTH_DEF,
    parameter int MAX_MAP_HEIGHT = dtfs_pkg::MAX_MAP_HEIGHT_DEF,
    parameter int CELL_SIZE      = dtfs_pkg::CELL_SIZE_DEF,
    parameter int SPLAT_RADIUS   = dtfs_pkg::SPLAT_RADIUS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic        [1:0]  operation,
    input  logic        [7:0]  pixel_x,
    input  logic        [7:0]  pixel_y,
    input  logic signed [15:0] flow_angle,
    input  logic signed [15:0] flow_value,
    input  logic        [5:0]  cell_col,
    input  logic        [5:0]  cell_row,
    // result
    output logic               result_valid,
    output logic signed [31:0] cell_value,
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [14:0] cfg_data
);

    localparam int DEPTH      = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SPAN       = 2 * SPLAT_RADIUS + 1;
    localparam int NBR        = SPAN * SPAN;
    localparam int OFS_W      = $clog2(SPAN);
    localparam int NBR_W      = $clog2(NBR);
    localparam int CELL_RECIP = (65536 + CELL_SIZE - 1) / CELL_SIZE;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_TUNE  = 3'd2;
    localparam logic [2:0] ST_SPLAT = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_FETCH = 3'd6;

    // Control state
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [OFS_W-1:0]  ox_reg, ox_next;
    logic [OFS_W-1:0]  oy_reg, oy_next;
    logic [NBR_W-1:0]  k_reg, k_next;
    logic              v0_reg, v0_next;
    logic              v1_reg, v1_next;
    logic              tune_go_reg, tune_go_next;
    logic              result_valid_reg, result_valid_next;
    logic [14:0]       pref_reg, pref_next;
    logic [6:0]        map_width_reg, map_width_next;
    logic [6:0]        map_height_reg, map_height_next;

    // Payload
    logic        [7:0]  px_reg, py_reg;
    logic signed [15:0] angle_reg, fv_reg;
    logic        [5:0]  col_reg, row_reg;
    logic        [7:0]  cx_reg, cy_reg;
    logic signed [31:0] scaled_reg;
    logic signed [47:0] prod_reg;
    logic [ADDR_W-1:0]  addr0_reg, addr1_reg;
    logic               in0_reg, in1_reg;
    logic signed [25:0] c_reg;
    logic               read_in_reg;
    logic signed [31:0] cell_value_reg, cell_value_next;

    // Map memory
    logic [31:0]       map_mem [DEPTH];
    logic [31:0]       mem_rd_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic               accept;
    logic               tune_valid;
    logic signed [31:0] tune_scaled;
    logic [8:0]         w_eff;
    logic [8:0]         h_eff;
    logic [24:0]        cx_prod;
    logic [24:0]        cy_prod;
    logic signed [10:0] nx;
    logic signed [10:0] ny;
    logic               nbr_in;
    logic [ADDR_W-1:0]  nbr_addr;
    logic [15:0]        weight_tbl [NBR];
    logic signed [48:0] wprod;
    logic signed [47:0] rnd;
    logic signed [32:0] sum;
    logic [31:0]        sat_sum;
    logic               read_in;
    logic [ADDR_W-1:0]  read_addr;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Distance weights per neighbor, worked out at elaboration
    for (genvar g = 0; g < NBR; g++)
    begin : g_weight
        localparam int DX = g % SPAN - SPLAT_RADIUS;
        localparam int DY = g / SPAN - SPLAT_RADIUS;
        localparam longint unsigned ROOT =
            dtfs_pkg::isqrt64(longint'(DX * DX + DY * DY) << 32);
        localparam longint WGT =
            32768 - longint'((ROOT + 2 * SPLAT_RADIUS) / (4 * SPLAT_RADIUS));
        assign weight_tbl[g] = 16'(WGT);
    end

    // Tuning and scaling pipeline
    dtfs_tune u_tune
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (tune_go_reg),
        .flow_angle          (angle_reg),
        .flow_value          (fv_reg),
        .preferred_direction (pref_reg),
        .out_valid           (tune_valid),
        .scaled              (tune_scaled)
    );

    // Clamp the map size in use
    always_comb
    begin
        if (map_width_reg == 7'd0)
            w_eff = 9'd1;
        else if ({2'b00, map_width_reg} > 9'(MAX_MAP_WIDTH))
            w_eff = 9'(MAX_MAP_WIDTH);
        else
            w_eff = {2'b00, map_width_reg};
        if (map_height_reg == 7'd0)
            h_eff = 9'd1;
        else if ({2'b00, map_height_reg} > 9'(MAX_MAP_HEIGHT))
            h_eff = 9'(MAX_MAP_HEIGHT);
        else
            h_eff = {2'b00, map_height_reg};
    end

    // Pixel to cell through the reciprocal of the cell size
    assign cx_prod = 25'(px_reg) * 25'(CELL_RECIP);
    assign cy_prod = 25'(py_reg) * 25'(CELL_RECIP);

    // Neighbor cell of the current offset
    assign nx       = 11'(int'(cx_reg) + int'(ox_reg) - SPLAT_RADIUS);
    assign ny       = 11'(int'(cy_reg) + int'(oy_reg) - SPLAT_RADIUS);
    assign nbr_in   = !nx[10] && !ny[10] && (nx[9:0] < {1'b0, w_eff})
                      && (ny[9:0] < {1'b0, h_eff});
    assign nbr_addr = ADDR_W'(int'(ny[9:0]) * MAX_MAP_WIDTH + int'(nx[9:0]));
    assign wprod    = scaled_reg * $signed({1'b0, weight_tbl[k_reg]});

    // Round the contribution to Q16.16
    assign rnd = prod_reg + 48'sd2097152;

    // Add and saturate
    assign sum     = {mem_rd_reg[31], mem_rd_reg} + 33'(c_reg);
    assign sat_sum = (sum[32] != sum[31]) ? {sum[32], {31{!sum[32]}}} : sum[31:0];

    // Read address
    assign read_in   = ({3'b000, col_reg} < w_eff) && ({3'b000, row_reg} < h_eff);
    assign read_addr = ADDR_W'(int'(row_reg) * MAX_MAP_WIDTH + int'(col_reg));

    // Memory port selection
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 32'd0;
        end
        else
        begin
            mem_we    = v1_reg && in1_reg;
            mem_waddr = addr1_reg;
            mem_wdata = sat_sum;
        end
        mem_raddr = (state_reg == ST_READ) ? read_addr : addr0_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        ox_next           = ox_reg;
        oy_next           = oy_reg;
        k_next            = k_reg;
        v0_next           = 1'b0;
        v1_next           = v0_reg;
        tune_go_next      = 1'b0;
        result_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        dtfs_pkg::OP_CLEAR:
                        begin
                            state_next    = ST_CLEAR;
                            clr_addr_next = '0;
                        end
                        dtfs_pkg::OP_ACCUM:
                        begin
                            state_next   = ST_TUNE;
                            tune_go_next = 1'b1;
                        end
                        dtfs_pkg::OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next    = ST_IDLE;
                    clr_addr_next = '0;
                end
            end
            ST_TUNE:
            begin
                if (tune_valid)
                begin
                    state_next = ST_SPLAT;
                    ox_next    = '0;
                    oy_next    = '0;
                    k_next     = '0;
                end
            end
            ST_SPLAT:
            begin
                v0_next = 1'b1;
                k_next  = k_reg + 1'b1;
                if (ox_reg == OFS_W'(SPAN - 1))
                begin
                    ox_next = '0;
                    oy_next = oy_reg + 1'b1;
                end
                else
                begin
                    ox_next = ox_reg + 1'b1;
                end
                if (k_reg == NBR_W'(NBR - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v0_reg)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next        = ST_IDLE;
                result_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Register writes
    always_comb
    begin
        pref_next       = pref_reg;
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dtfs_pkg::CFG_PREF_DIR:   pref_next       = cfg_data;
                dtfs_pkg::CFG_MAP_WIDTH:  map_width_next  = cfg_data[6:0];
                dtfs_pkg::CFG_MAP_HEIGHT: map_height_next = cfg_data[6:0];
                default:                  pref_next       = pref_reg;
            endcase
        end
    end

    assign cell_value_next = read_in_reg ? $signed(mem_rd_reg) : 32'sd0;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            ox_reg           <= '0;
            oy_reg           <= '0;
            k_reg            <= '0;
            v0_reg           <= 1'b0;
            v1_reg           <= 1'b0;
            tune_go_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            pref_reg         <= dtfs_pkg::PREF_DIR_RST;
            map_width_reg    <= dtfs_pkg::MAP_WIDTH_RST;
            map_height_reg   <= dtfs_pkg::MAP_HEIGHT_RST;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            ox_reg           <= ox_next;
            oy_reg           <= oy_next;
            k_reg            <= k_next;
            v0_reg           <= v0_next;
            v1_reg           <= v1_next;
            tune_go_reg      <= tune_go_next;
            result_valid_reg <= result_valid_next;
            pref_reg         <= pref_next;
            map_width_reg    <= map_width_next;
            map_height_reg   <= map_height_next;
        end
    end

    // Capture the transaction and move the splat pipe
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= pixel_x;
            py_reg    <= pixel_y;
            angle_reg <= flow_angle;
            fv_reg    <= flow_value;
            col_reg   <= cell_col;
            row_reg   <= cell_row;
        end
        cx_reg      <= cx_prod[23:16];
        cy_reg      <= cy_prod[23:16];
        if (state_reg == ST_TUNE)
            scaled_reg <= tune_scaled;
        prod_reg    <= wprod[47:0];
        addr0_reg   <= nbr_addr;
        in0_reg     <= nbr_in;
        c_reg       <= rnd[47:22];
        addr1_reg   <= addr0_reg;
        in1_reg     <= in0_reg;
        read_in_reg <= read_in;
        if (state_reg == ST_FETCH)
            cell_value_reg <= cell_value_next;
    end

    // Map memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        mem_rd_reg <= map_mem[mem_raddr];
    end

    assign result_valid = result_valid_reg;
    assign cell_value   = cell_value_reg;

    // Checks
    `ASSERT_NEVER(a_idle_pipe_empty, clk, rst_n, (state_reg == ST_IDLE) && (v0_reg || v1_reg))
    `ASSERT_NEVER(a_no_write_idle, clk, rst_n, mem_we && (state_reg == ST_IDLE))
    `ASSERT_AFTER3(a_read_answers, clk, rst_n, accept && (operation == dtfs_pkg::OP_READ), result_valid)
    `ASSERT_IMPLY(a_result_idle, clk, rst_n, result_valid, !v0_reg && !v1_reg && !mem_we)

endmodule
